@@ rtl/frg_pkg.sv @@
package frg_pkg;

    // field width of numerator and denominator, two's complement
    localparam int VALUE_WIDTH = 32;
    localparam int MAG_W       = VALUE_WIDTH - 1;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int PC_W        = 5;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] numerator_in;
        logic signed [VALUE_WIDTH-1:0] denominator_in;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] numerator_out;
        logic signed [VALUE_WIDTH-1:0] denominator_out;
        logic        [MAG_W-1:0]       common_divisor;
    } result_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_HALVE_AB,
        OP_HALVE_A,
        OP_HALVE_B,
        OP_SUB,
        OP_DIV_NUM_START,
        OP_DIV_STEP,
        OP_DIV_DEN_START,
        OP_SAVE_DEN,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_INPUT,
        C_NOT_POS,
        C_ANY_ODD,
        C_A_ODD,
        C_B_ODD,
        C_B_NONZERO,
        C_DIV_MORE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic no_input;
        logic not_pos;
        logic any_odd;
        logic a_odd;
        logic b_odd;
        logic b_nonzero;
        logic div_more;
        logic out_free;
    } status_t;

    // program labels
    localparam logic [PC_W-1:0] L_IDLE      = PC_W'(0);
    localparam logic [PC_W-1:0] L_CHECK     = PC_W'(1);
    localparam logic [PC_W-1:0] L_TWOS      = PC_W'(2);
    localparam logic [PC_W-1:0] L_TWOS_DO   = PC_W'(3);
    localparam logic [PC_W-1:0] L_A_EVEN    = PC_W'(4);
    localparam logic [PC_W-1:0] L_A_DO      = PC_W'(5);
    localparam logic [PC_W-1:0] L_B_EVEN    = PC_W'(6);
    localparam logic [PC_W-1:0] L_B_DO      = PC_W'(7);
    localparam logic [PC_W-1:0] L_SUB       = PC_W'(8);
    localparam logic [PC_W-1:0] L_SUB_TEST  = PC_W'(9);
    localparam logic [PC_W-1:0] L_DIV_NUM   = PC_W'(10);
    localparam logic [PC_W-1:0] L_NUM_LOOP  = PC_W'(11);
    localparam logic [PC_W-1:0] L_DIV_DEN   = PC_W'(12);
    localparam logic [PC_W-1:0] L_DEN_LOOP  = PC_W'(13);
    localparam logic [PC_W-1:0] L_SAVE_DEN  = PC_W'(14);
    localparam logic [PC_W-1:0] L_EMIT      = PC_W'(15);
    localparam logic [PC_W-1:0] L_EMIT_WAIT = PC_W'(16);

    // microprogram: binary gcd, then two restoring divisions by the gcd
    function automatic ctrl_word_t frg_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: L_IDLE};
        case (pc)
            L_IDLE:      w = '{op: OP_LOAD,          cond: C_NO_INPUT,  target: L_IDLE};
            L_CHECK:     w = '{op: OP_NOP,           cond: C_NOT_POS,   target: L_EMIT};
            L_TWOS:      w = '{op: OP_NOP,           cond: C_ANY_ODD,   target: L_A_EVEN};
            L_TWOS_DO:   w = '{op: OP_HALVE_AB,      cond: C_ALWAYS,    target: L_TWOS};
            L_A_EVEN:    w = '{op: OP_NOP,           cond: C_A_ODD,     target: L_B_EVEN};
            L_A_DO:      w = '{op: OP_HALVE_A,       cond: C_ALWAYS,    target: L_A_EVEN};
            L_B_EVEN:    w = '{op: OP_NOP,           cond: C_B_ODD,     target: L_SUB};
            L_B_DO:      w = '{op: OP_HALVE_B,       cond: C_ALWAYS,    target: L_B_EVEN};
            L_SUB:       w = '{op: OP_SUB,           cond: C_ALWAYS,    target: L_SUB_TEST};
            L_SUB_TEST:  w = '{op: OP_NOP,           cond: C_B_NONZERO, target: L_B_EVEN};
            L_DIV_NUM:   w = '{op: OP_DIV_NUM_START, cond: C_ALWAYS,    target: L_NUM_LOOP};
            L_NUM_LOOP:  w = '{op: OP_DIV_STEP,      cond: C_DIV_MORE,  target: L_NUM_LOOP};
            L_DIV_DEN:   w = '{op: OP_DIV_DEN_START, cond: C_ALWAYS,    target: L_DEN_LOOP};
            L_DEN_LOOP:  w = '{op: OP_DIV_STEP,      cond: C_DIV_MORE,  target: L_DEN_LOOP};
            L_SAVE_DEN:  w = '{op: OP_SAVE_DEN,      cond: C_ALWAYS,    target: L_EMIT};
            L_EMIT:      w = '{op: OP_EMIT,          cond: C_OUT_FREE,  target: L_IDLE};
            L_EMIT_WAIT: w = '{op: OP_NOP,           cond: C_ALWAYS,    target: L_EMIT};
            default:     w = '{op: OP_NOP,           cond: C_ALWAYS,    target: L_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/fraction_reduce_by_gcd.sv @@
// Reduces one signed fraction to lowest terms and reports the divisor taken out.
// When both values are positive the gcd is found by a binary (shift and subtract)
// loop and both values are divided by it with a shared restoring divider, one
// quotient bit per cycle; otherwise the pair passes through with divisor 1.
// One item is worked at a time under a small microprogram. The gcd loop is data
// dependent, with at most about 2*VALUE_WIDTH subtracts and 2*VALUE_WIDTH halvings.
// A new item is taken while the previous result still waits in the output
// register. A full output register holds the finished item in place until the
// register frees up.
module fraction_reduce_by_gcd (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  frg_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output frg_pkg::result_t result
);

    localparam int W  = frg_pkg::VALUE_WIDTH;
    localparam int MW = frg_pkg::MAG_W;
    localparam int CW = frg_pkg::CNT_W;

    frg_pkg::ctrl_word_t ctrl;
    frg_pkg::status_t    status;

    logic signed [W-1:0] num_reg;
    logic signed [W-1:0] den_reg;
    logic [MW-1:0]       a_reg;
    logic [MW-1:0]       b_reg;
    logic [CW-1:0]       k_reg;
    logic [MW-1:0]       g_reg;
    logic [MW-1:0]       quo_reg;
    logic [MW-1:0]       rem_reg;
    logic [CW-1:0]       cnt_reg;
    logic                result_valid_reg;
    frg_pkg::result_t    result_reg;

    logic                out_free;
    logic [MW:0]         rem_shift;
    logic [MW:0]         rem_diff;
    logic                a_gt_b;

    frg_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // handshake
    assign item_ready   = (ctrl.op == frg_pkg::OP_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || result_ready;

    // divider step and gcd compare
    assign rem_shift = {rem_reg, quo_reg[MW-1]};
    assign rem_diff  = rem_shift - {1'b0, g_reg};
    assign a_gt_b    = (a_reg > b_reg);

    // flags for the sequencer
    always_comb
    begin
        status.no_input  = !item_valid;
        status.not_pos   = num_reg[W-1] || den_reg[W-1] || (num_reg == '0) || (den_reg == '0);
        status.any_odd   = a_reg[0] || b_reg[0];
        status.a_odd     = a_reg[0];
        status.b_odd     = b_reg[0];
        status.b_nonzero = (b_reg != '0);
        status.div_more  = (cnt_reg != CW'(1));
        status.out_free  = out_free;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            frg_pkg::OP_LOAD:
            begin
                num_reg <= item.numerator_in;
                den_reg <= item.denominator_in;
                a_reg   <= item.numerator_in[MW-1:0];
                b_reg   <= item.denominator_in[MW-1:0];
                k_reg   <= '0;
                g_reg   <= MW'(1);
            end
            frg_pkg::OP_HALVE_AB:
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            frg_pkg::OP_HALVE_A:
            begin
                a_reg <= a_reg >> 1;
            end
            frg_pkg::OP_HALVE_B:
            begin
                b_reg <= b_reg >> 1;
            end
            frg_pkg::OP_SUB:
            begin
                if (a_gt_b)
                begin
                    a_reg <= b_reg;
                    b_reg <= a_reg - b_reg;
                end
                else
                begin
                    b_reg <= b_reg - a_reg;
                end
            end
            frg_pkg::OP_DIV_NUM_START:
            begin
                g_reg   <= a_reg << k_reg;
                quo_reg <= num_reg[MW-1:0];
                rem_reg <= '0;
                cnt_reg <= CW'(MW);
            end
            frg_pkg::OP_DIV_STEP:
            begin
                if (!rem_diff[MW])
                begin
                    rem_reg <= rem_diff[MW-1:0];
                    quo_reg <= {quo_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[MW-1:0];
                    quo_reg <= {quo_reg[MW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
            frg_pkg::OP_DIV_DEN_START:
            begin
                num_reg <= {1'b0, quo_reg};
                quo_reg <= den_reg[MW-1:0];
                rem_reg <= '0;
                cnt_reg <= CW'(MW);
            end
            frg_pkg::OP_SAVE_DEN:
            begin
                den_reg <= {1'b0, quo_reg};
            end
            frg_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    result_reg.numerator_out   <= num_reg;
                    result_reg.denominator_out <= den_reg;
                    result_reg.common_divisor  <= g_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output item valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctrl.op == frg_pkg::OP_EMIT && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/frg_sequencer.sv @@
module frg_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  frg_pkg::status_t    status,
    output frg_pkg::ctrl_word_t ctrl
);

    logic [frg_pkg::PC_W-1:0] pc_reg;
    logic [frg_pkg::PC_W-1:0] pc_next;
    logic                     take;

    // control word for the current step
    assign ctrl = frg_pkg::frg_rom(pc_reg);

    // jump condition select
    always_comb
    begin
        case (ctrl.cond)
            frg_pkg::C_ALWAYS:    take = 1'b1;
            frg_pkg::C_NO_INPUT:  take = status.no_input;
            frg_pkg::C_NOT_POS:   take = status.not_pos;
            frg_pkg::C_ANY_ODD:   take = status.any_odd;
            frg_pkg::C_A_ODD:     take = status.a_odd;
            frg_pkg::C_B_ODD:     take = status.b_odd;
            frg_pkg::C_B_NONZERO: take = status.b_nonzero;
            frg_pkg::C_DIV_MORE:  take = status.div_more;
            frg_pkg::C_OUT_FREE:  take = status.out_free;
            default:              take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= frg_pkg::L_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
